/* hw/rtl/stack_calculator_machine_defines.svh */
// assertion macros for the stack calculator checker
`ifndef STACK_CALCULATOR_MACHINE_DEFINES_SVH
`define STACK_CALCULATOR_MACHINE_DEFINES_SVH

// same-cycle implication, held off during reset
`define STCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack calculator check failed");

// next-cycle implication, held off during reset
`define STCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack calculator check failed");

`endif

/* hw/rtl/stcm_pkg.sv */
// shared constants, command codes and control structs of the stack calculator
package stcm_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 256;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int OP_W        = 4;
  localparam int DIGIT_W     = 4;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TUSER_W = ST_W + 1;

  // commands
  localparam logic [OP_W-1:0] OP_PUSH  = 4'd0;
  localparam logic [OP_W-1:0] OP_PRINT = 4'd1;
  localparam logic [OP_W-1:0] OP_DUP   = 4'd2;
  localparam logic [OP_W-1:0] OP_DROP  = 4'd3;
  localparam logic [OP_W-1:0] OP_SWAP  = 4'd4;
  localparam logic [OP_W-1:0] OP_OVER  = 4'd5;
  localparam logic [OP_W-1:0] OP_ROT   = 4'd6;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd7;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd8;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd9;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd10;
  localparam logic [OP_W-1:0] OP_MOD   = 4'd11;

  // result status
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_DIVZ  = 2'd2;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd3;

  // operand register load select
  localparam logic [1:0] LD_NONE = 2'd0;
  localparam logic [1:0] LD_A    = 2'd1;
  localparam logic [1:0] LD_B    = 2'd2;
  localparam logic [1:0] LD_C    = 2'd3;

  // result register source
  localparam logic [2:0] RES_ADD = 3'd0;
  localparam logic [2:0] RES_SUB = 3'd1;
  localparam logic [2:0] RES_MUL = 3'd2;
  localparam logic [2:0] RES_QUO = 3'd3;
  localparam logic [2:0] RES_REM = 3'd4;

  // stack write source
  localparam logic [2:0] SRC_DIGIT = 3'd0;
  localparam logic [2:0] SRC_A     = 3'd1;
  localparam logic [2:0] SRC_B     = 3'd2;
  localparam logic [2:0] SRC_C     = 3'd3;
  localparam logic [2:0] SRC_RES   = 3'd4;

  // stack count update
  localparam logic [2:0] CNT_KEEP = 3'd0;
  localparam logic [2:0] CNT_INC  = 3'd1;
  localparam logic [2:0] CNT_DEC  = 3'd2;
  localparam logic [2:0] CNT_DEC2 = 3'd3;
  localparam logic [2:0] CNT_CLR  = 3'd4;

  typedef struct packed {
    logic            cap_in;     // latch the digit of an accepted beat
    logic            rd_en;
    logic [1:0]      rd_off;     // read at count - rd_off
    logic [1:0]      ld_sel;
    logic            res_ld;
    logic [2:0]      res_sel;
    logic            div_start;
    logic            wr_en;
    logic [1:0]      wr_off;     // write at count - wr_off
    logic [2:0]      wr_src;
    logic [2:0]      cnt_op;
    logic            out_load;
    logic            out_print;
    logic [ST_W-1:0] out_status;
  } stcm_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_lt2;
    logic cnt_lt3;
    logic cnt_full;
    logic a_zero;
    logic div_done;
  } stcm_sts_t;

endpackage

/* hw/rtl/stcm_divider.sv */
// iterative signed divider, one quotient bit per cycle, truncating
module stcm_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [stcm_pkg::DATA_W-1:0]     dividend,
  input  logic [stcm_pkg::DATA_W-1:0]     divisor,
  output logic [stcm_pkg::DATA_W-1:0]     quot,
  output logic [stcm_pkg::DATA_W-1:0]     rem,
  output logic                            done
);

  localparam int STEP_W = $clog2(stcm_pkg::DATA_W);

  logic [stcm_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [stcm_pkg::DATA_W-1:0] quo_r, quo_nxt;
  logic [stcm_pkg::DATA_W-1:0] dvs_r;
  logic [STEP_W-1:0]           step_r;
  logic                        busy_r, done_r;
  logic                        negq_r, negr_r;
  logic [stcm_pkg::DATA_W:0]   shifted, diff;
  logic [stcm_pkg::DATA_W-1:0] mag_n, mag_d;

  // magnitudes; the most negative word maps to 2^(w-1) as unsigned
  assign mag_n = dividend[stcm_pkg::DATA_W-1] ? -dividend : dividend;
  assign mag_d = divisor[stcm_pkg::DATA_W-1]  ? -divisor  : divisor;

  always_comb begin
    shifted = {rem_r, quo_r[stcm_pkg::DATA_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (!diff[stcm_pkg::DATA_W]) begin
      rem_nxt = diff[stcm_pkg::DATA_W-1:0];
      quo_nxt = {quo_r[stcm_pkg::DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[stcm_pkg::DATA_W-1:0];
      quo_nxt = {quo_r[stcm_pkg::DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(stcm_pkg::DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= mag_n;
      dvs_r  <= mag_d;
      negq_r <= dividend[stcm_pkg::DATA_W-1] ^ divisor[stcm_pkg::DATA_W-1];
      negr_r <= dividend[stcm_pkg::DATA_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quot = negq_r ? -quo_r : quo_r;
  assign rem  = negr_r ? -rem_r : rem_r;
  assign done = done_r;

endmodule

/* hw/rtl/stcm_datapath.sv */
// stack memory, stack count, operand registers, alu, divider and result register
module stcm_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stcm_pkg::stcm_cmd_t             cmd,
  input  logic [stcm_pkg::DIGIT_W-1:0]    in_digit,
  output stcm_pkg::stcm_sts_t             sts,
  output logic [stcm_pkg::DATA_W-1:0]     out_value,
  output logic                            out_value_valid,
  output logic [stcm_pkg::ST_W-1:0]       out_status
);

  logic [stcm_pkg::DATA_W-1:0]  mem [stcm_pkg::STACK_DEPTH];
  logic [stcm_pkg::DATA_W-1:0]  rdata_r;
  logic [stcm_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [stcm_pkg::DIGIT_W-1:0] digit_r;
  logic [stcm_pkg::DATA_W-1:0]  a_r, b_r, c_r, res_r;
  logic [stcm_pkg::DATA_W-1:0]  value_r;
  logic                         vvalid_r;
  logic [stcm_pkg::ST_W-1:0]    status_r;
  logic [stcm_pkg::CNT_W-1:0]   raddr_full, waddr_full;
  logic [stcm_pkg::ADDR_W-1:0]  raddr, waddr;
  logic [stcm_pkg::DATA_W-1:0]  wdata, mul_lo, res_nxt;
  logic [stcm_pkg::DATA_W-1:0]  div_quot, div_rem;
  logic                         div_done;

  stcm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (b_r),
    .divisor  (a_r),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  // offsets are taken from the count held at the start of the command
  assign raddr_full = count_r - stcm_pkg::CNT_W'(cmd.rd_off);
  assign waddr_full = count_r - stcm_pkg::CNT_W'(cmd.wr_off);
  assign raddr      = raddr_full[stcm_pkg::ADDR_W-1:0];
  assign waddr      = waddr_full[stcm_pkg::ADDR_W-1:0];

  always_comb begin
    unique case (cmd.wr_src)
      stcm_pkg::SRC_DIGIT: wdata = stcm_pkg::DATA_W'(digit_r);
      stcm_pkg::SRC_A:     wdata = a_r;
      stcm_pkg::SRC_B:     wdata = b_r;
      stcm_pkg::SRC_C:     wdata = c_r;
      stcm_pkg::SRC_RES:   wdata = res_r;
      default:             wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // b is the left operand, a (the old top) the right one
  assign mul_lo = b_r * a_r;

  always_comb begin
    unique case (cmd.res_sel)
      stcm_pkg::RES_ADD: res_nxt = b_r + a_r;
      stcm_pkg::RES_SUB: res_nxt = b_r - a_r;
      stcm_pkg::RES_MUL: res_nxt = mul_lo;
      stcm_pkg::RES_QUO: res_nxt = div_quot;
      stcm_pkg::RES_REM: res_nxt = div_rem;
      default:           res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      digit_r <= in_digit;
    end
    unique case (cmd.ld_sel)
      stcm_pkg::LD_A:    a_r <= rdata_r;
      stcm_pkg::LD_B:    b_r <= rdata_r;
      stcm_pkg::LD_C:    c_r <= rdata_r;
      default: ;
    endcase
    if (cmd.res_ld) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      value_r  <= cmd.out_print ? a_r : '0;
      vvalid_r <= cmd.out_print;
      status_r <= cmd.out_status;
    end
  end

  always_comb begin
    unique case (cmd.cnt_op)
      stcm_pkg::CNT_KEEP: count_nxt = count_r;
      stcm_pkg::CNT_INC:  count_nxt = count_r + stcm_pkg::CNT_W'(1);
      stcm_pkg::CNT_DEC:  count_nxt = count_r - stcm_pkg::CNT_W'(1);
      stcm_pkg::CNT_DEC2: count_nxt = count_r - stcm_pkg::CNT_W'(2);
      stcm_pkg::CNT_CLR:  count_nxt = '0;
      default:            count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign sts.cnt_zero = (count_r == '0);
  assign sts.cnt_lt2  = (count_r < stcm_pkg::CNT_W'(2));
  assign sts.cnt_lt3  = (count_r < stcm_pkg::CNT_W'(3));
  assign sts.cnt_full = (count_r == stcm_pkg::CNT_W'(stcm_pkg::STACK_DEPTH));
  assign sts.a_zero   = (a_r == '0);
  assign sts.div_done = div_done;

  assign out_value       = value_r;
  assign out_value_valid = vvalid_r;
  assign out_status      = status_r;

endmodule

/* hw/rtl/stcm_ctrl.sv */
// command sequencer: checks, stack reads, alu or divide, stack writes, result hand-off
module stcm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [stcm_pkg::OP_W-1:0]     in_op,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  stcm_pkg::stcm_sts_t           sts,
  output stcm_pkg::stcm_cmd_t           cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RD0    = 4'd2;
  localparam logic [3:0] S_RD1    = 4'd3;
  localparam logic [3:0] S_RD2    = 4'd4;
  localparam logic [3:0] S_LD     = 4'd5;
  localparam logic [3:0] S_EXEC   = 4'd6;
  localparam logic [3:0] S_DIVW   = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  typedef struct packed {
    logic [2:0] src;
    logic [1:0] off;
    logic       last;
    logic [2:0] cnt_op;
  } wr_step_t;

  logic [3:0]                  state_r, state_nxt;
  logic [stcm_pkg::OP_W-1:0]   op_r;
  logic [stcm_pkg::ST_W-1:0]   st_r, st_nxt;
  logic [2:0]                  cntop_r, cntop_nxt;
  logic                        print_r, print_nxt;
  logic [1:0]                  wstep_r, wstep_nxt;
  logic                        out_tvalid_r;
  logic                        out_free;
  logic [1:0]                  nrd;
  wr_step_t                    wstep;

  // number of words a command reads from the top
  function automatic logic [1:0] rd_num(input logic [stcm_pkg::OP_W-1:0] op);
    logic [1:0] n;
    n = 2'd2;
    unique case (op)
      stcm_pkg::OP_PRINT, stcm_pkg::OP_DUP: n = 2'd1;
      stcm_pkg::OP_ROT:                     n = 2'd3;
      default:                              n = 2'd2;
    endcase
    return n;
  endfunction

  // write sequence per command, offsets below the starting count
  function automatic wr_step_t wr_step(input logic [stcm_pkg::OP_W-1:0] op,
                                       input logic [1:0] step);
    wr_step_t w;
    w = '{src: stcm_pkg::SRC_RES, off: 2'd2, last: 1'b1, cnt_op: stcm_pkg::CNT_DEC};
    unique case (op)
      stcm_pkg::OP_PUSH:
        w = '{src: stcm_pkg::SRC_DIGIT, off: 2'd0, last: 1'b1, cnt_op: stcm_pkg::CNT_INC};
      stcm_pkg::OP_DUP:
        w = '{src: stcm_pkg::SRC_A, off: 2'd0, last: 1'b1, cnt_op: stcm_pkg::CNT_INC};
      stcm_pkg::OP_OVER:
        w = '{src: stcm_pkg::SRC_B, off: 2'd0, last: 1'b1, cnt_op: stcm_pkg::CNT_INC};
      stcm_pkg::OP_SWAP: begin
        if (step == 2'd0) begin
          w = '{src: stcm_pkg::SRC_A, off: 2'd2, last: 1'b0, cnt_op: stcm_pkg::CNT_KEEP};
        end else begin
          w = '{src: stcm_pkg::SRC_B, off: 2'd1, last: 1'b1, cnt_op: stcm_pkg::CNT_KEEP};
        end
      end
      stcm_pkg::OP_ROT: begin
        if (step == 2'd0) begin
          w = '{src: stcm_pkg::SRC_B, off: 2'd3, last: 1'b0, cnt_op: stcm_pkg::CNT_KEEP};
        end else if (step == 2'd1) begin
          w = '{src: stcm_pkg::SRC_A, off: 2'd2, last: 1'b0, cnt_op: stcm_pkg::CNT_KEEP};
        end else begin
          w = '{src: stcm_pkg::SRC_C, off: 2'd1, last: 1'b1, cnt_op: stcm_pkg::CNT_KEEP};
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  assign nrd      = rd_num(op_r);
  assign wstep    = wr_step(op_r, wstep_r);
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cntop_nxt = cntop_r;
    print_nxt = print_r;
    wstep_nxt = wstep_r;
    cmd       = '0;
    in_tready = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap_in = 1'b1;
          st_nxt     = stcm_pkg::ST_OK;
          cntop_nxt  = stcm_pkg::CNT_KEEP;
          print_nxt  = 1'b0;
          wstep_nxt  = 2'd0;
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_RD0;
        unique case (op_r)
          stcm_pkg::OP_PUSH: begin
            if (sts.cnt_full) begin
              st_nxt    = stcm_pkg::ST_OVER;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_WR;
            end
          end
          stcm_pkg::OP_PRINT: begin
            if (sts.cnt_zero) begin
              st_nxt    = stcm_pkg::ST_UNDER;
              state_nxt = S_FIN;
            end
          end
          stcm_pkg::OP_DUP: begin
            priority if (sts.cnt_zero) begin
              st_nxt    = stcm_pkg::ST_UNDER;
              state_nxt = S_FIN;
            end else if (sts.cnt_full) begin
              st_nxt    = stcm_pkg::ST_OVER;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_RD0;
            end
          end
          stcm_pkg::OP_DROP: begin
            state_nxt = S_FIN;
            if (sts.cnt_zero) begin
              st_nxt = stcm_pkg::ST_UNDER;
            end else begin
              cntop_nxt = stcm_pkg::CNT_DEC;
            end
          end
          stcm_pkg::OP_OVER: begin
            priority if (sts.cnt_lt2) begin
              st_nxt    = stcm_pkg::ST_UNDER;
              cntop_nxt = stcm_pkg::CNT_CLR;
              state_nxt = S_FIN;
            end else if (sts.cnt_full) begin
              st_nxt    = stcm_pkg::ST_OVER;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_RD0;
            end
          end
          stcm_pkg::OP_ROT: begin
            if (sts.cnt_lt3) begin
              st_nxt    = stcm_pkg::ST_UNDER;
              cntop_nxt = stcm_pkg::CNT_CLR;
              state_nxt = S_FIN;
            end
          end
          stcm_pkg::OP_SWAP, stcm_pkg::OP_ADD, stcm_pkg::OP_SUB, stcm_pkg::OP_MUL,
          stcm_pkg::OP_DIV, stcm_pkg::OP_MOD: begin
            if (sts.cnt_lt2) begin
              st_nxt    = stcm_pkg::ST_UNDER;
              cntop_nxt = stcm_pkg::CNT_CLR;
              state_nxt = S_FIN;
            end
          end
          default: state_nxt = S_FIN;  // unused codes do nothing
        endcase
      end

      // reads are issued one per cycle, data lands in rdata_r in the following cycle
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = 2'd1;
        state_nxt  = (nrd == 2'd1) ? S_LD : S_RD1;
      end

      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = 2'd2;
        cmd.ld_sel = stcm_pkg::LD_A;
        state_nxt  = (nrd == 2'd2) ? S_LD : S_RD2;
      end

      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = 2'd3;
        cmd.ld_sel = stcm_pkg::LD_B;
        state_nxt  = S_LD;
      end

      S_LD: begin
        unique case (nrd)
          2'd1:    cmd.ld_sel = stcm_pkg::LD_A;
          2'd2:    cmd.ld_sel = stcm_pkg::LD_B;
          default: cmd.ld_sel = stcm_pkg::LD_C;
        endcase
        unique case (op_r)
          stcm_pkg::OP_PRINT: begin
            print_nxt = 1'b1;
            cntop_nxt = stcm_pkg::CNT_DEC;
            state_nxt = S_FIN;
          end
          stcm_pkg::OP_DUP, stcm_pkg::OP_SWAP, stcm_pkg::OP_OVER,
          stcm_pkg::OP_ROT: state_nxt = S_WR;
          default:          state_nxt = S_EXEC;
        endcase
      end

      S_EXEC: begin
        state_nxt = S_WR;
        unique case (op_r)
          stcm_pkg::OP_ADD: begin
            cmd.res_ld  = 1'b1;
            cmd.res_sel = stcm_pkg::RES_ADD;
          end
          stcm_pkg::OP_SUB: begin
            cmd.res_ld  = 1'b1;
            cmd.res_sel = stcm_pkg::RES_SUB;
          end
          stcm_pkg::OP_MUL: begin
            cmd.res_ld  = 1'b1;
            cmd.res_sel = stcm_pkg::RES_MUL;
          end
          default: begin
            // divide by zero drops both operands and pushes nothing
            if (sts.a_zero) begin
              st_nxt    = stcm_pkg::ST_DIVZ;
              cntop_nxt = stcm_pkg::CNT_DEC2;
              state_nxt = S_FIN;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIVW;
            end
          end
        endcase
      end

      S_DIVW: begin
        if (sts.div_done) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = (op_r == stcm_pkg::OP_DIV) ? stcm_pkg::RES_QUO : stcm_pkg::RES_REM;
          state_nxt   = S_WR;
        end
      end

      S_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = wstep.src;
        cmd.wr_off = wstep.off;
        if (wstep.last) begin
          cntop_nxt = wstep.cnt_op;
          state_nxt = S_FIN;
        end else begin
          wstep_nxt = wstep_r + 2'd1;
        end
      end

      S_FIN: begin
        // count moves together with the result beat
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_print  = print_r;
          cmd.out_status = st_r;
          cmd.cnt_op     = cntop_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_r <= in_op;
    end
    st_r    <= st_nxt;
    cntop_r <= cntop_nxt;
    print_r <= print_nxt;
    wstep_r <= wstep_nxt;
  end

  assign out_tvalid = out_tvalid_r;

endmodule

/* hw/rtl/stack_calculator_machine.sv */
// stack calculator top level: stream ports, sequencer and datapath
//
// Forth-style calculator on a 256-word stack of 32-bit signed words, one command per
// input beat and exactly one result beat per command. Div and mod run on the 32-step
// divider; the stack memory serves one read or one write per cycle. Only one command
// is in flight, but a finished result waits in the output register, so the next
// command is accepted while the previous beat is still stalled; that command then
// holds in its last cycle until the output register is free. Arithmetic wraps,
// division truncates, status reports underflow, divide by zero and overflow.
module stack_calculator_machine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [stcm_pkg::IN_TDATA_W-1:0]     in_tdata,   // [3:0] digit, [7:4] zero
  input  logic [stcm_pkg::OP_W-1:0]           in_tuser,   // [3:0] op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [stcm_pkg::DATA_W-1:0]         out_tdata,  // [31:0] value
  output logic [stcm_pkg::OUT_TUSER_W-1:0]    out_tuser   // [0] value_valid, [2:1] status
);

  stcm_pkg::stcm_cmd_t         cmd;
  stcm_pkg::stcm_sts_t         sts;
  logic                        value_valid;
  logic [stcm_pkg::ST_W-1:0]   status;

  stcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  stcm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_digit        (in_tdata[stcm_pkg::DIGIT_W-1:0]),
    .sts             (sts),
    .out_value       (out_tdata),
    .out_value_valid (value_valid),
    .out_status      (status)
  );

  assign out_tuser = {status, value_valid};

endmodule

/* hw/rtl/stack_calculator_machine_chk.sv */
// port-level checks for the stack calculator, bound to the top level
`include "stack_calculator_machine_defines.svh"

module stack_calculator_machine_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [stcm_pkg::DATA_W-1:0]         out_tdata,
  input logic [stcm_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  // a printed word always comes with ok status
  `STCM_ASSERT_IMP(a_print_ok, clk, rst_n, out_tvalid && out_tuser[0], out_tuser[2:1] == stcm_pkg::ST_OK)

  // value is zero on every beat that carries no printed word
  `STCM_ASSERT_IMP(a_noprint_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0)

  // one command at a time: ready drops right after a beat is taken
  `STCM_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // a stalled result beat holds
  `STCM_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind stack_calculator_machine stack_calculator_machine_chk u_chk (.*);
